// File: rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
`default_nettype none

package sem_pkg;

	// Geometry and result widths fixed by the register map and result format
	localparam int DIM_BITS    = 11;
	localparam int CNT_BITS    = 10;
	localparam int MAG_BITS    = 11;
	localparam int COUNT_LIMIT = 1024;

	localparam logic [DIM_BITS-1:0] DIM_MIN      = 11'd3;
	localparam logic [DIM_BITS-1:0] DIM_MAX      = 11'd1024;
	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd400;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd400;

	// First row and column whose pixel completes an interior window
	localparam logic [CNT_BITS-1:0] FIRST_INTERIOR = 10'd2;

	// Configuration register map
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_IDX  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT_IDX = 2'd1;

	typedef struct packed {
		logic [CFG_INDEX_BITS-1:0] reg_index;
		logic [DIM_BITS-1:0]       value;
	} sem_cfg_t;

	typedef struct packed {
		logic [MAG_BITS-1:0] magnitude;
		logic [CNT_BITS-1:0] out_row;
		logic [CNT_BITS-1:0] out_col;
		logic                frame_end;
	} sem_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQUARE,
		ST_ROOT,
		ST_EMIT
	} sem_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic load;
		logic square;
		logic root_step;
		logic emit;
	} sem_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic due;
		logic root_done;
		logic out_hold;
	} sem_status_t;

endpackage

`default_nettype wire

// File: rtl/sem_if.sv
// Valid/ready stream interface used for the pixel, result and configuration channels.
`default_nettype none

interface sem_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/sem_ctrl.sv
// Controller state machine sequencing one pixel through the datapath.
`default_nettype none

module sem_ctrl import sem_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pix_valid,
	output logic             pix_ready,
	input  wire sem_status_t status,
	output sem_cmd_t         cmd
);

	sem_state_t state_q;
	sem_state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_valid) state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				state_nx = status.due ? ST_SQUARE : ST_IDLE;
			end
			ST_SQUARE: begin
				state_nx = ST_ROOT;
			end
			ST_ROOT: begin
				if (status.root_done) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_hold) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		pix_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pix_ready  = 1'b1;
				cmd.accept = pix_valid;
			end
			ST_LOAD:   cmd.load      = 1'b1;
			ST_SQUARE: cmd.square    = 1'b1;
			ST_ROOT:   cmd.root_step = 1'b1;
			ST_EMIT:   cmd.emit      = !status.out_hold;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/sem_datapath.sv
// Datapath: line stores, 3x3 window, Sobel sums, bit-serial square root and result register.
`default_nettype none

module sem_datapath import sem_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sem_cmd_t              cmd,
	output sem_status_t                status,
	input  wire logic [PIXEL_BITS-1:0] pixel,
	input  wire logic                  cfg_write,
	input  wire sem_cfg_t              cfg_data,
	input  wire logic                  res_ready,
	output logic                       res_valid,
	output sem_result_t                res_data
);

	localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int W_HI = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
	localparam int GW   = PIXEL_BITS + 3;
	localparam int RB   = GW;
	localparam int SQW  = 2 * GW;
	localparam int SCW  = $clog2(RB);

	localparam logic [DIM_BITS-1:0] W_HI_V    = DIM_BITS'(W_HI);
	localparam logic [SCW-1:0]      STEP_LAST = SCW'(RB - 1);

	logic [DIM_BITS-1:0]   frame_w_q;
	logic [DIM_BITS-1:0]   frame_h_q;
	logic [DIM_BITS-1:0]   w_used;
	logic [DIM_BITS-1:0]   h_used;
	logic [CNT_BITS-1:0]   row_q;
	logic [CNT_BITS-1:0]   col_q;
	logic [DIM_BITS-1:0]   row_inc;
	logic [DIM_BITS-1:0]   col_inc;
	logic                  geom_write;

	logic [PIXEL_BITS-1:0] px_q;
	logic [AW-1:0]         idx_q;
	logic [CNT_BITS-1:0]   row_tag_q;
	logic [CNT_BITS-1:0]   col_tag_q;
	logic                  end_tag_q;
	logic                  due_q;

	logic [PIXEL_BITS-1:0] top_rd;
	logic [PIXEL_BITS-1:0] mid_rd;
	logic [PIXEL_BITS-1:0] win_q  [9];
	logic [PIXEL_BITS-1:0] win_nx [9];

	logic [GW-1:0]         gx_pos;
	logic [GW-1:0]         gx_neg;
	logic [GW-1:0]         gy_pos;
	logic [GW-1:0]         gy_neg;
	logic signed [GW-1:0]  gx_q;
	logic signed [GW-1:0]  gy_q;
	logic signed [SQW-1:0] gx_sq;
	logic signed [SQW-1:0] gy_sq;

	logic [SQW-1:0]        rad_q;
	logic [RB+1:0]         rem_q;
	logic [RB-1:0]         root_q;
	logic [SCW-1:0]        step_q;
	logic [RB+1:0]         rem_sh;
	logic [RB+1:0]         trial;
	logic                  trial_ok;

	logic                  res_valid_q;
	sem_result_t           res_q;

	// Clamp geometry to the supported range
	always_comb begin
		if (frame_w_q < DIM_MIN) begin
			w_used = DIM_MIN;
		end else if (frame_w_q > W_HI_V) begin
			w_used = W_HI_V;
		end else begin
			w_used = frame_w_q;
		end
		if (frame_h_q < DIM_MIN) begin
			h_used = DIM_MIN;
		end else if (frame_h_q > DIM_MAX) begin
			h_used = DIM_MAX;
		end else begin
			h_used = frame_h_q;
		end
	end

	assign geom_write = cfg_write &&
		(cfg_data.reg_index == CFG_WIDTH_IDX || cfg_data.reg_index == CFG_HEIGHT_IDX);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= WIDTH_RESET;
			frame_h_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_data.reg_index)
				CFG_WIDTH_IDX:  frame_w_q <= cfg_data.value;
				CFG_HEIGHT_IDX: frame_h_q <= cfg_data.value;
				default: begin
				end
			endcase
		end
	end

	assign col_inc = {1'b0, col_q} + DIM_BITS'(1);
	assign row_inc = {1'b0, row_q} + DIM_BITS'(1);

	// Raster position: advance per transaction, wrap at row and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (geom_write) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.accept) begin
			if (col_inc >= w_used) begin
				col_q <= '0;
				if (row_inc >= h_used) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[CNT_BITS-1:0];
				end
			end else begin
				col_q <= col_inc[CNT_BITS-1:0];
			end
		end
	end

	// Capture the pixel and its result tags
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q      <= pixel;
			idx_q     <= AW'(col_q);
			row_tag_q <= row_q - CNT_BITS'(1);
			col_tag_q <= col_q - CNT_BITS'(1);
			end_tag_q <= ({1'b0, row_q} == h_used - DIM_BITS'(1)) &&
				({1'b0, col_q} == w_used - DIM_BITS'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q <= 1'b0;
		end else if (cmd.accept) begin
			due_q <= (row_q >= FIRST_INTERIOR) && (col_q >= FIRST_INTERIOR);
		end
	end

	// Line stores: upper holds two rows back, middle one row back
	sem_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_upper (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (idx_q),
		.wdata (mid_rd),
		.raddr (AW'(col_q)),
		.rdata (top_rd)
	);

	sem_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_middle (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (idx_q),
		.wdata (px_q),
		.raddr (AW'(col_q)),
		.rdata (mid_rd)
	);

	// Shift the window left and insert the new column
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nx[k*3]     = win_q[k*3 + 1];
			win_nx[k*3 + 1] = win_q[k*3 + 2];
		end
		win_nx[2] = top_rd;
		win_nx[5] = mid_rd;
		win_nx[8] = px_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (cmd.load) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= win_nx[k];
			end
		end
	end

	// Sobel sums on the updated window
	always_comb begin
		gx_pos = GW'(win_nx[2]) + (GW'(win_nx[5]) << 1) + GW'(win_nx[8]);
		gx_neg = GW'(win_nx[0]) + (GW'(win_nx[3]) << 1) + GW'(win_nx[6]);
		gy_pos = GW'(win_nx[6]) + (GW'(win_nx[7]) << 1) + GW'(win_nx[8]);
		gy_neg = GW'(win_nx[0]) + (GW'(win_nx[1]) << 1) + GW'(win_nx[2]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gx_q <= signed'(gx_pos - gx_neg);
			gy_q <= signed'(gy_pos - gy_neg);
		end
	end

	// Squares, full width
	assign gx_sq = gx_q * gx_q;
	assign gy_sq = gy_q * gy_q;

	// Square root, one result bit per cycle
	assign rem_sh   = {rem_q[RB-1:0], rad_q[SQW-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign trial_ok = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			rad_q  <= $unsigned(gx_sq) + $unsigned(gy_sq);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= trial_ok ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RB-2:0], trial_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.square) begin
			step_q <= '0;
		end else if (cmd.root_step) begin
			step_q <= step_q + SCW'(1);
		end
	end

	// Output register: load on emit, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.magnitude <= MAG_BITS'(root_q);
			res_q.out_row   <= row_tag_q;
			res_q.out_col   <= col_tag_q;
			res_q.frame_end <= end_tag_q;
		end
	end

	assign res_valid        = res_valid_q;
	assign res_data         = res_q;
	assign status.due       = due_q;
	assign status.root_done = (step_q == STEP_LAST);
	assign status.out_hold  = res_valid_q && !res_ready;

endmodule

`default_nettype wire

// File: rtl/sobel_edge_magnitude_3x3_core.sv
// Top level of the Sobel 3x3 edge magnitude core.
// Pixels enter in raster order on pix; each interior pixel yields one result on res
// carrying floor(sqrt(Gx^2 + Gy^2)), the centre's row and column, and a frame_end flag
// on the last result of the frame. Border pixels pass through accept and line store
// update and give no result. An interior pixel passes through accept, line store read
// and window update, squaring, the bit-serial square root, then the load of the result
// register. The result register lets the next pixel be taken while a result waits.
// Geometry is written on cfg (index 0 width, index 1 height, clamped to 3..1024, width
// also to MAX_WIDTH); either write restarts the frame.
`default_nettype none

module sobel_edge_magnitude_3x3_core import sem_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input wire logic    clk,
	input wire logic    arst_n,
	sem_stream_if.sink   pix,
	sem_stream_if.source res,
	sem_stream_if.sink   cfg
);

	sem_cmd_t    cmd;
	sem_status_t status;
	logic        pix_ready;
	logic        res_valid;
	sem_result_t res_data;
	logic [PIXEL_BITS-1:0] pixel;
	sem_cfg_t    cfg_data;

	assign pixel    = pix.data;
	assign cfg_data = cfg.data;

	// Sequencer
	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_ready (pix_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath
	sem_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pixel     (pixel),
		.cfg_write (cfg.valid),
		.cfg_data  (cfg_data),
		.res_ready (res.ready),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	assign pix.ready = pix_ready;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid;
	assign res.data  = res_data;

endmodule

`default_nettype wire
